// ===== design/ima_pkg.sv =====
// Shared types and constants for the interval motif affinity block.
// Holds the controller state encoding, the command and status bundles and fixed widths.
// No dependencies.
package ima_pkg;

    // Fixed field widths
    localparam int IVL_W     = 8;
    localparam int S_TDATA_W = 8;
    localparam int SCORE_W   = 11;
    localparam int M_TDATA_W = 16;
    localparam int PAIR_W    = 5;

    // Scoring constants: points are twentieths, scores are 1/1200 units
    localparam int SIGN_PTS  = 14;
    localparam int EQUAL_PTS = 6;
    localparam int NEAR_PTS  = 3;
    localparam int MIN_LEN   = 3;
    localparam int SCALE_NUM = 60;
    localparam int SCORE_MAX = 1200;

    // Item kind carried on tuser
    localparam logic FUNC_SUBJECT = 1'b0;
    localparam logic FUNC_TOCCATA = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCORE,
        ST_REDUCE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic exec;
        logic score;
        logic reduce;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

// ===== design/ima_ctrl.sv =====
// Sequencer for the interval motif affinity block.
// Steps each beat through execute, score and, on the last beat, reduce and emit.
// Depends on ima_pkg.
module ima_ctrl #(
    parameter int SUBJECT_HEAD = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid_i,
    input  logic                 in_last_i,
    output logic                 in_ready_o,
    input  ima_pkg::dp_status_t  status_i,
    output ima_pkg::ctrl_cmd_t   cmd_o
);

    localparam int RCNT_W = (SUBJECT_HEAD > 1) ? $clog2(SUBJECT_HEAD) : 1;

    ima_pkg::ctrl_state_t state_reg, state_next;
    logic [RCNT_W-1:0]    rcnt_reg, rcnt_next;
    logic                 last_reg, last_next;
    logic                 accept;
    logic                 reduce_done;

    assign accept      = in_valid_i && in_ready_o;
    assign reduce_done = (rcnt_reg == RCNT_W'(SUBJECT_HEAD - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ima_pkg::ST_IDLE: begin
                if (in_valid_i) begin
                    state_next = ima_pkg::ST_SCORE;
                end
            end
            ima_pkg::ST_SCORE: begin
                state_next = last_reg ? ima_pkg::ST_REDUCE : ima_pkg::ST_IDLE;
            end
            ima_pkg::ST_REDUCE: begin
                if (reduce_done) begin
                    state_next = ima_pkg::ST_EMIT;
                end
            end
            ima_pkg::ST_EMIT: begin
                if (!status_i.out_busy) begin
                    state_next = ima_pkg::ST_IDLE;
                end
            end
            default: state_next = ima_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready_o    = 1'b0;
        cmd_o         = '0;
        unique case (state_reg)
            ima_pkg::ST_IDLE: begin
                in_ready_o = 1'b1;
                cmd_o.exec = in_valid_i;
            end
            ima_pkg::ST_SCORE:  cmd_o.score  = 1'b1;
            ima_pkg::ST_REDUCE: cmd_o.reduce = 1'b1;
            ima_pkg::ST_EMIT:   cmd_o.emit   = !status_i.out_busy;
            default: begin
                in_ready_o = 1'b0;
            end
        endcase
    end

    always_comb begin
        last_next = accept ? in_last_i : last_reg;
        rcnt_next = (state_reg == ima_pkg::ST_REDUCE) ? rcnt_reg + RCNT_W'(1) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ima_pkg::ST_IDLE;
            rcnt_reg  <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            rcnt_reg  <= rcnt_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ===== design/ima_dp.sv =====
// Datapath of the interval motif affinity block: subject store, diagonal
// window sums, per-position best scores, final reduction and result register.
// Depends on ima_pkg.
module ima_dp #(
    parameter int SUBJECT_HEAD = 8,
    parameter int MAX_TOCCATA  = 64,
    parameter int MAX_WINDOW   = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ima_pkg::ctrl_cmd_t                  cmd_i,
    output ima_pkg::dp_status_t                 status_o,
    input  logic                                in_func_i,
    input  logic signed [ima_pkg::IVL_W-1:0]    in_interval_i,
    input  logic                                out_ready_i,
    output logic                                out_valid_o,
    output logic [ima_pkg::SCORE_W-1:0]         out_score_o,
    output logic                                out_short_o,
    output logic                                out_trunc_o
);

    localparam int IVL_W   = ima_pkg::IVL_W;
    localparam int SCORE_W = ima_pkg::SCORE_W;
    localparam int PAIR_W  = ima_pkg::PAIR_W;
    localparam int MIN_LEN = ima_pkg::MIN_LEN;
    localparam int NUM_LEN = MAX_WINDOW - MIN_LEN + 1;
    localparam int SCNT_W  = $clog2(SUBJECT_HEAD + 1);
    localparam int SIDX_W  = $clog2(SUBJECT_HEAD);
    localparam int TCNT_W  = $clog2(MAX_TOCCATA + 1);
    localparam int DIAG_W  =
        $clog2((ima_pkg::SIGN_PTS + ima_pkg::EQUAL_PTS) * MAX_WINDOW + 1);

    function automatic logic [PAIR_W-1:0] pair_score(
        input logic signed [IVL_W-1:0] s,
        input logic signed [IVL_W:0]   t
    );
        logic signed [IVL_W:0] s_x;
        logic [IVL_W:0]        mag_s;
        logic [IVL_W:0]        mag_t;
        logic [IVL_W:0]        diff;
        logic [1:0]            sgn_s;
        logic [1:0]            sgn_t;
        logic [PAIR_W-1:0]     sc;
        s_x   = (IVL_W + 1)'(s);
        mag_s = s_x[IVL_W] ? $unsigned(-s_x) : $unsigned(s_x);
        mag_t = t[IVL_W] ? $unsigned(-t) : $unsigned(t);
        diff  = (mag_s >= mag_t) ? mag_s - mag_t : mag_t - mag_s;
        // sign class: negative, zero or positive
        sgn_s = {s_x[IVL_W], s_x == '0};
        sgn_t = {t[IVL_W], t == '0};
        sc    = '0;
        if (sgn_s == sgn_t) begin
            sc = PAIR_W'(ima_pkg::SIGN_PTS);
        end
        if (diff == '0) begin
            sc = sc + PAIR_W'(ima_pkg::EQUAL_PTS);
        end else if (diff == (IVL_W + 1)'(1)) begin
            sc = sc + PAIR_W'(ima_pkg::NEAR_PTS);
        end
        return sc;
    endfunction

    logic signed [IVL_W-1:0] subj_reg  [SUBJECT_HEAD];
    logic signed [IVL_W-1:0] subj_next [SUBJECT_HEAD];
    logic [SCNT_W-1:0]       subj_cnt_reg, subj_cnt_next;
    logic [TCNT_W-1:0]       toc_cnt_reg, toc_cnt_next;
    logic                    ovf_reg, ovf_next;
    logic [DIAG_W-1:0]       diag_reg  [MAX_WINDOW][2][SUBJECT_HEAD];
    logic [DIAG_W-1:0]       diag_next [MAX_WINDOW][2][SUBJECT_HEAD];
    logic [SCORE_W-1:0]      best_e_reg  [SUBJECT_HEAD];
    logic [SCORE_W-1:0]      best_e_next [SUBJECT_HEAD];
    logic [SCORE_W-1:0]      best_reg, best_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SCORE_W-1:0]      out_score_reg, out_score_next;
    logic                    out_short_reg, out_short_next;
    logic                    out_trunc_reg, out_trunc_next;

    logic [PAIR_W-1:0]       pair_w [2][SUBJECT_HEAD];
    logic [SCORE_W-1:0]      avg_w  [NUM_LEN][2][SUBJECT_HEAD];
    logic signed [IVL_W:0]   t_pos;
    logic signed [IVL_W:0]   t_neg;
    logic                    is_toccata;
    logic                    take_subject;
    logic                    take_toccata;
    logic                    drop_toccata;
    logic                    short_job;

    assign is_toccata   = (in_func_i == ima_pkg::FUNC_TOCCATA);
    assign take_subject = cmd_i.exec && !is_toccata && (toc_cnt_reg == '0) &&
                          (subj_cnt_reg < SCNT_W'(SUBJECT_HEAD));
    assign take_toccata = cmd_i.exec && is_toccata &&
                          (toc_cnt_reg < TCNT_W'(MAX_TOCCATA));
    assign drop_toccata = cmd_i.exec && is_toccata &&
                          (toc_cnt_reg >= TCNT_W'(MAX_TOCCATA));
    assign short_job    = (subj_cnt_reg < SCNT_W'(MIN_LEN)) ||
                          (toc_cnt_reg < TCNT_W'(MIN_LEN));

    // Pair scores of the incoming interval and its negation against every kept subject
    always_comb begin
        t_pos = (IVL_W + 1)'(in_interval_i);
        t_neg = -t_pos;
        for (int e = 0; e < SUBJECT_HEAD; e++) begin
            if (SCNT_W'(e) < subj_cnt_reg) begin
                pair_w[0][e] = pair_score(subj_reg[e], t_pos);
                pair_w[1][e] = pair_score(subj_reg[e], t_neg);
            end else begin
                pair_w[0][e] = '0;
                pair_w[1][e] = '0;
            end
        end
    end

    // Diagonal k ending at subject e: new pair score plus diagonal k-1 ending at e-1
    always_comb begin
        diag_next = diag_reg;
        if (take_toccata) begin
            for (int k = 0; k < MAX_WINDOW; k++) begin
                for (int v = 0; v < 2; v++) begin
                    for (int e = 0; e < SUBJECT_HEAD; e++) begin
                        if (k == 0 || e == 0) begin
                            diag_next[k][v][e] = DIAG_W'(pair_w[v][e]);
                        end else begin
                            diag_next[k][v][e] = diag_reg[k-1][v][e-1] +
                                                 DIAG_W'(pair_w[v][e]);
                        end
                    end
                end
            end
        end
    end

    // Scaled window averages, zero where the window does not exist yet
    for (genvar gl = MIN_LEN; gl <= MAX_WINDOW; gl++) begin : g_len
        localparam int SCALE = ima_pkg::SCALE_NUM / gl;
        for (genvar gv = 0; gv < 2; gv++) begin : g_sign
            for (genvar ge = 0; ge < SUBJECT_HEAD; ge++) begin : g_pos
                if (ge >= gl - 1) begin : g_live
                    assign avg_w[gl-MIN_LEN][gv][ge] =
                        ((toc_cnt_reg >= TCNT_W'(gl)) && (subj_cnt_reg > SCNT_W'(ge))) ?
                        SCORE_W'(SCORE_W'(diag_reg[gl-1][gv][ge]) * SCORE_W'(SCALE)) :
                        '0;
                end else begin : g_none
                    assign avg_w[gl-MIN_LEN][gv][ge] = '0;
                end
            end
        end
    end

    always_comb begin
        logic [SCORE_W-1:0] run_max;
        best_e_next = best_e_reg;
        best_next   = best_reg;
        run_max     = '0;
        if (cmd_i.emit) begin
            for (int e = 0; e < SUBJECT_HEAD; e++) begin
                best_e_next[e] = '0;
            end
            best_next = '0;
        end else if (cmd_i.score) begin
            for (int e = 0; e < SUBJECT_HEAD; e++) begin
                run_max = best_e_reg[e];
                for (int l = 0; l < NUM_LEN; l++) begin
                    for (int v = 0; v < 2; v++) begin
                        if (avg_w[l][v][e] > run_max) begin
                            run_max = avg_w[l][v][e];
                        end
                    end
                end
                best_e_next[e] = run_max;
            end
        end else if (cmd_i.reduce) begin
            // shift the per-position bests past a single compare
            for (int e = 0; e < SUBJECT_HEAD - 1; e++) begin
                best_e_next[e] = best_e_reg[e+1];
            end
            best_e_next[SUBJECT_HEAD-1] = '0;
            if (best_e_reg[0] > best_reg) begin
                best_next = best_e_reg[0];
            end
        end
    end

    always_comb begin
        subj_next     = subj_reg;
        subj_cnt_next = subj_cnt_reg;
        toc_cnt_next  = toc_cnt_reg;
        ovf_next      = ovf_reg;
        if (cmd_i.emit) begin
            subj_cnt_next = '0;
            toc_cnt_next  = '0;
            ovf_next      = 1'b0;
        end else begin
            if (take_subject) begin
                subj_next[subj_cnt_reg[SIDX_W-1:0]] = in_interval_i;
                subj_cnt_next = subj_cnt_reg + SCNT_W'(1);
            end
            if (take_toccata) begin
                toc_cnt_next = toc_cnt_reg + TCNT_W'(1);
            end
            if (drop_toccata) begin
                ovf_next = 1'b1;
            end
        end
    end

    always_comb begin
        out_score_next = out_score_reg;
        out_short_next = out_short_reg;
        out_trunc_next = out_trunc_reg;
        out_valid_next = out_valid_reg && !out_ready_i;
        if (cmd_i.emit) begin
            out_valid_next = 1'b1;
            out_score_next = short_job ? '0 : best_reg;
            out_short_next = short_job;
            out_trunc_next = ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        subj_reg      <= subj_next;
        diag_reg      <= diag_next;
        out_score_reg <= out_score_next;
        out_short_reg <= out_short_next;
        out_trunc_reg <= out_trunc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            subj_cnt_reg  <= '0;
            toc_cnt_reg   <= '0;
            ovf_reg       <= 1'b0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int e = 0; e < SUBJECT_HEAD; e++) begin
                best_e_reg[e] <= '0;
            end
        end else begin
            subj_cnt_reg  <= subj_cnt_next;
            toc_cnt_reg   <= toc_cnt_next;
            ovf_reg       <= ovf_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
            best_e_reg    <= best_e_next;
        end
    end

    assign status_o.out_busy = out_valid_reg && !out_ready_i;
    assign out_valid_o       = out_valid_reg;
    assign out_score_o       = out_score_reg;
    assign out_short_o       = out_short_reg;
    assign out_trunc_o       = out_trunc_reg;

    a_short_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_short_reg) |-> (out_score_reg == '0))
        else $error("short job reported a nonzero score");

    a_score_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_score_reg <= SCORE_W'(ima_pkg::SCORE_MAX)))
        else $error("score above full scale");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (toc_cnt_reg <= TCNT_W'(MAX_TOCCATA)) && (subj_cnt_reg <= SCNT_W'(SUBJECT_HEAD)))
        else $error("item count beyond capacity");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.emit |=> (toc_cnt_reg == '0) && (subj_cnt_reg == '0) && (best_reg == '0))
        else $error("job state not cleared after result");

    a_subject_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        ((toc_cnt_reg != '0) && !cmd_i.emit) |=> $stable(subj_cnt_reg))
        else $error("subject stored after toccata started");

endmodule

// ===== design/interval_motif_affinity.sv =====
// Interval motif affinity: top level joining the sequencer and the datapath.
// Order: a non-last beat is scored in the cycle after acceptance; a last beat then passes
//   through the reduce and emit states before its result shows on m_tvalid.
// Pacing: beats are taken only from idle, after the previous beat is scored; the last
//   beat adds a reduce step per subject position, then an emit held while a result waits.
// Reset: aresetn low at a clock edge clears counts, flags, best scores and the result valid.
module interval_motif_affinity #(
    parameter int SUBJECT_HEAD = 8,
    parameter int MAX_TOCCATA  = 64,
    parameter int MAX_WINDOW   = 6
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ima_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] interval (signed)
    input  logic                            s_tuser,   // [0] func: 0 subject, 1 toccata
    input  logic                            s_tlast,   // closes the job
    // result beats
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ima_pkg::M_TDATA_W-1:0]   m_tdata    // [10:0] score, [11] too_short,
                                                       // [12] toccata_truncated, [15:13] zero
);

    localparam int SCORE_W = ima_pkg::SCORE_W;

    ima_pkg::ctrl_cmd_t  cmd;
    ima_pkg::dp_status_t status;

    logic [SCORE_W-1:0]  score;
    logic                too_short;
    logic                truncated;

    // Sequencer: accepts a beat only from idle; holds the job through reduce and emit.
    ima_ctrl #(
        .SUBJECT_HEAD (SUBJECT_HEAD)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid_i (s_tvalid),
        .in_last_i  (s_tlast),
        .in_ready_o (s_tready),
        .status_i   (status),
        .cmd_o      (cmd)
    );

    // Datapath: consumes the input payload on the accept cycle itself, so no
    // input register is needed; the result register lets a new job start while
    // the previous result still waits on m_tready.
    ima_dp #(
        .SUBJECT_HEAD (SUBJECT_HEAD),
        .MAX_TOCCATA  (MAX_TOCCATA),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_i         (cmd),
        .status_o      (status),
        .in_func_i     (s_tuser),
        .in_interval_i ($signed(s_tdata[ima_pkg::IVL_W-1:0])),
        .out_ready_i   (m_tready),
        .out_valid_o   (m_tvalid),
        .out_score_o   (score),
        .out_short_o   (too_short),
        .out_trunc_o   (truncated)
    );

    // Pack the result beat, lowest field first, zero-filled to whole bytes.
    assign m_tdata = {(ima_pkg::M_TDATA_W - SCORE_W - 2)'(0), truncated, too_short, score};

endmodule
